// ===== rtl/prf_pkg.sv =====
`default_nettype none

package prf_pkg;

  // Fixed field widths of the stream payloads.
  localparam int unsigned PAGE_IN_W   = 16;
  localparam int unsigned FRAME_IDX_W = 2;
  localparam int unsigned EVICT_W     = 16;
  localparam int unsigned FAULT_W     = 16;
  localparam int unsigned OUT_DATA_W  = 40;

  // Input item kind, carried on s_tuser.
  typedef enum logic {
    OP_REFERENCE = 1'b0,
    OP_FLUSH     = 1'b1
  } opcode_t;

  // Replacement policy register values.
  typedef enum logic {
    POLICY_FIFO = 1'b0,
    POLICY_LRU  = 1'b1
  } policy_t;

  // Priority flags rippled from frame 0 upward through the cell row.
  typedef struct packed {
    logic match;
    logic empty;
    logic lru;
  } chain_t;

  // Per-beat command broadcast to every cell.
  typedef struct packed {
    logic step;   // reference beat accepted
    logic flush;  // flush beat accepted
    logic load;   // fault: write the page into the used frame
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/page_replacement_fifo_lru_top.sv =====
// Page replacement unit over a row of page frames, FIFO or LRU policy.
// Input stream: s_tdata carries the page number, s_tuser the opcode
// (reference or flush). Output stream: one result beat per input beat with
// hit, frame index, evicted flag, evicted page and the saturating fault count.
// The user must write the policy register through cfg_wen/cfg_wdata while
// idle; the block does not enforce this. Each frame is a cell; lookups ripple
// through the row combinationally, and each result is loaded into the output
// register. Throughput is one beat per cycle while s_tready is high, set by
// the single pass over the cell row. The result register frees in the same
// cycle the receiver takes it, so s_tready falls only while a result waits and
// m_tready is low; the receiver stalling holds the result and the state.
// Reset empties all frames, clears the ranks, the FIFO pointer, the fault
// count and the policy (FIFO); no clearing pass is needed.
`default_nettype none

module page_replacement_fifo_lru_top #(
  parameter int unsigned FRAMES    = 4,
  parameter int unsigned PAGE_BITS = 16
) (
  input  wire         clk,
  input  wire         rst,
  // Configuration: policy_mode
  input  wire         cfg_wen,
  input  wire         cfg_wdata,
  // Input stream
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [15:0] s_tdata,   // [15:0] page
  input  wire         s_tuser,   // [0] opcode
  // Output stream
  output logic        m_tvalid,
  input  wire         m_tready,
  // [0] hit, [2:1] frame_index, [3] evicted_valid, [19:4] evicted_page,
  // [35:20] fault_count, [39:36] zero
  output logic [39:0] m_tdata
);

  localparam int unsigned IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned RW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned PW = (PAGE_BITS < prf_pkg::PAGE_IN_W) ?
                               PAGE_BITS : prf_pkg::PAGE_IN_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(FRAMES - 1);

  prf_pkg::policy_t    policy_mode;
  logic [IW-1:0]       fifo_ptr;
  logic [IW-1:0]       fifo_ptr_next;
  logic [prf_pkg::FAULT_W-1:0] fault_total;
  logic [prf_pkg::FAULT_W-1:0] fault_total_next;
  logic                out_valid;
  logic [prf_pkg::OUT_DATA_W-1:0] out_data;
  logic [prf_pkg::OUT_DATA_W-1:0] out_data_next;

  logic                accept;
  logic                is_flush;
  logic [PW-1:0]       req_page;
  prf_pkg::cell_ctrl_t ctrl;

  prf_pkg::chain_t     chain   [FRAMES+1];
  logic [IW-1:0]       m_idx   [FRAMES+1];
  logic [IW-1:0]       e_idx   [FRAMES+1];
  logic [IW-1:0]       l_idx   [FRAMES+1];
  logic [RW+PW-1:0]    sel_acc [FRAMES+1];

  logic                hit;
  logic                any_empty;
  logic                evict;
  logic [IW-1:0]       used_idx;
  logic [RW:0]         old_rank;
  logic [RW-1:0]       sel_rank;
  logic [PW-1:0]       sel_page;

  // Handshake and command decode.
  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign is_flush = (prf_pkg::opcode_t'(s_tuser) == prf_pkg::OP_FLUSH);
  assign req_page = s_tdata[PW-1:0];

  assign ctrl.step  = accept && !is_flush;
  assign ctrl.flush = accept && is_flush;
  assign ctrl.load  = accept && !is_flush && !hit;

  // Chain heads.
  assign chain[0]   = '0;
  assign m_idx[0]   = '0;
  assign e_idx[0]   = '0;
  assign l_idx[0]   = '0;
  assign sel_acc[0] = '0;

  // Row of frame cells.
  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    prf_cell #(
      .FRAMES (FRAMES),
      .PW     (PW),
      .INDEX  (g)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctrl          (ctrl),
      .req_page      (req_page),
      .used_idx      (used_idx),
      .old_rank      (old_rank),
      .chain_in      (chain[g]),
      .match_idx_in  (m_idx[g]),
      .empty_idx_in  (e_idx[g]),
      .lru_idx_in    (l_idx[g]),
      .sel_in        (sel_acc[g]),
      .chain_out     (chain[g+1]),
      .match_idx_out (m_idx[g+1]),
      .empty_idx_out (e_idx[g+1]),
      .lru_idx_out   (l_idx[g+1]),
      .sel_out       (sel_acc[g+1])
    );
  end

  // Pick the frame used by this reference.
  assign hit       = chain[FRAMES].match;
  assign any_empty = chain[FRAMES].empty;
  assign evict     = !hit && !any_empty;
  assign sel_rank  = sel_acc[FRAMES][RW+PW-1:PW];
  assign sel_page  = sel_acc[FRAMES][PW-1:0];

  always_comb begin
    if (hit) begin
      used_idx = m_idx[FRAMES];
    end else if (any_empty) begin
      used_idx = e_idx[FRAMES];
    end else if (policy_mode == prf_pkg::POLICY_LRU) begin
      used_idx = l_idx[FRAMES];
    end else begin
      used_idx = fifo_ptr;
    end
  end

  // A freshly filled frame counts as older than every valid frame.
  assign old_rank = (!hit && any_empty) ? (RW+1)'(FRAMES) : {1'b0, sel_rank};

  // FIFO pointer and fault count.
  always_comb begin
    fifo_ptr_next    = fifo_ptr;
    fault_total_next = fault_total;
    if (ctrl.flush) begin
      fifo_ptr_next    = '0;
      fault_total_next = '0;
    end else if (ctrl.step && !hit) begin
      if (evict && policy_mode == prf_pkg::POLICY_FIFO) begin
        fifo_ptr_next = (fifo_ptr == LAST_IDX) ? '0 : IW'(fifo_ptr + 1'b1);
      end
      if (fault_total != '1) begin
        fault_total_next = fault_total + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_ptr    <= '0;
      fault_total <= '0;
    end else begin
      fifo_ptr    <= fifo_ptr_next;
      fault_total <= fault_total_next;
    end
  end

  // Policy register.
  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode <= prf_pkg::POLICY_FIFO;
    end else if (cfg_wen) begin
      policy_mode <= prf_pkg::policy_t'(cfg_wdata);
    end
  end

  // Result beat assembly.
  always_comb begin
    if (is_flush) begin
      out_data_next = '0;
    end else begin
      out_data_next = {4'b0000,
                       fault_total_next,
                       evict ? prf_pkg::EVICT_W'(sel_page) : {prf_pkg::EVICT_W{1'b0}},
                       evict,
                       prf_pkg::FRAME_IDX_W'(used_idx),
                       hit};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= out_data_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

`ifndef SYNTHESIS
  // A result never reports both a hit and an eviction.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data[0] && out_data[3]))
    else $error("result reports hit and eviction together");

  // A flush result carries a zero fault count.
  a_flush_zero: assert property (@(posedge clk) disable iff (rst)
    ctrl.flush |=> (out_data == '0 && fault_total == '0))
    else $error("flush did not clear the fault count");

  // The FIFO pointer stays inside the frame row.
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    fifo_ptr <= LAST_IDX)
    else $error("FIFO pointer out of range");

  // An LRU eviction only happens when an oldest frame was found.
  a_evict_lru: assert property (@(posedge clk) disable iff (rst)
    (ctrl.step && evict && policy_mode == prf_pkg::POLICY_LRU) |-> chain[FRAMES].lru)
    else $error("LRU eviction without an oldest frame");
`endif

endmodule

`default_nettype wire

// ===== rtl/prf_cell.sv =====
`default_nettype none

module prf_cell #(
  parameter int unsigned FRAMES = 4,
  parameter int unsigned PW     = 16,
  parameter int unsigned INDEX  = 0,
  localparam int unsigned IW    = (FRAMES > 1) ? $clog2(FRAMES) : 1,
  localparam int unsigned RW    = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire prf_pkg::cell_ctrl_t  ctrl,
  input  wire [PW-1:0]              req_page,
  input  wire [IW-1:0]              used_idx,
  input  wire [RW:0]                old_rank,
  input  wire prf_pkg::chain_t      chain_in,
  input  wire [IW-1:0]              match_idx_in,
  input  wire [IW-1:0]              empty_idx_in,
  input  wire [IW-1:0]              lru_idx_in,
  input  wire [RW+PW-1:0]           sel_in,
  output prf_pkg::chain_t           chain_out,
  output logic [IW-1:0]             match_idx_out,
  output logic [IW-1:0]             empty_idx_out,
  output logic [IW-1:0]             lru_idx_out,
  output logic [RW+PW-1:0]          sel_out
);

  localparam logic [IW-1:0] MY_IDX    = IW'(INDEX);
  localparam logic [RW-1:0] LAST_RANK = RW'(FRAMES - 1);

  logic          valid;
  logic [PW-1:0] page;
  logic [RW-1:0] rank;

  logic match_here;
  logic empty_here;
  logic lru_here;
  logic sel;

  // Local lookups on the stored frame.
  assign match_here = valid && (page == req_page);
  assign empty_here = !valid;
  assign lru_here   = valid && (rank == LAST_RANK);
  assign sel        = (used_idx == MY_IDX);

  // Lowest index wins: a lower cell that already found one keeps its index.
  always_comb begin
    chain_out.match = chain_in.match | match_here;
    chain_out.empty = chain_in.empty | empty_here;
    chain_out.lru   = chain_in.lru   | lru_here;
    match_idx_out   = chain_in.match ? match_idx_in : MY_IDX;
    empty_idx_out   = chain_in.empty ? empty_idx_in : MY_IDX;
    lru_idx_out     = chain_in.lru   ? lru_idx_in   : MY_IDX;
  end

  // The selected cell drives its rank and page onto the collection chain.
  assign sel_out = sel_in | (sel ? {rank, page} : '0);

  // Valid bit.
  always_ff @(posedge clk) begin
    if (rst || ctrl.flush) begin
      valid <= 1'b0;
    end else if (ctrl.load && sel) begin
      valid <= 1'b1;
    end
  end

  // Page store, written on a fault into this frame.
  always_ff @(posedge clk) begin
    if (ctrl.load && sel) begin
      page <= req_page;
    end
  end

  // Recency rank: the used frame becomes newest, younger valid frames age by one.
  always_ff @(posedge clk) begin
    if (rst || ctrl.flush) begin
      rank <= '0;
    end else if (ctrl.step) begin
      if (sel) begin
        rank <= '0;
      end else if (valid && ({1'b0, rank} < old_rank)) begin
        rank <= rank + 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  // A frame that is not valid (never filled, or flushed) keeps the newest rank.
  a_invalid_rank_zero: assert property (@(posedge clk) disable iff (rst)
    !valid |-> rank == '0)
    else $error("invalid frame holds a nonzero rank");

  // After a fault loads this frame it is valid and newest.
  a_load_newest: assert property (@(posedge clk) disable iff (rst)
    (ctrl.load && sel && !ctrl.flush) |=> (valid && rank == '0))
    else $error("loaded frame is not valid and newest");

  // A flushed frame is empty on the next cycle.
  a_flush_empty: assert property (@(posedge clk) disable iff (rst)
    ctrl.flush |=> !valid)
    else $error("frame still valid after flush");
`endif

endmodule

`default_nettype wire

// ===== sim/page_replacement_fifo_lru_top_tb.sv =====
`default_nettype none

module page_replacement_fifo_lru_top_tb;

  localparam int NUM_FRAMES = 4;
  localparam int STALL_LIMIT = 1000;
  localparam int MISS_RUN = 60;

  // Result beat in m_tdata order: the last field sits in the lowest bit.
  typedef struct packed {
    logic [15:0] fault_count;
    logic [15:0] evicted_page;
    logic        evicted_valid;
    logic [1:0]  frame_index;
    logic        hit;
  } lookup_result_t;

  typedef struct {
    prf_pkg::opcode_t op;
    logic [15:0]      page;
  } page_request_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [15:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tready = 1'b0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [39:0] m_tdata;

  page_replacement_fifo_lru_top #(
    .FRAMES(NUM_FRAMES),
    .PAGE_BITS(16)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_wen(cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  // Shadow of the frame table and the policy register.
  logic [15:0] frame_page [NUM_FRAMES];
  bit          frame_held [NUM_FRAMES];
  logic [1:0]  frame_rank [NUM_FRAMES];
  logic [1:0]  oldest_frame = '0;
  logic [15:0] fault_tally = '0;
  prf_pkg::policy_t policy = prf_pkg::POLICY_FIFO;

  page_request_t  page_requests [$];
  lookup_result_t lookup_results_due [$];

  bit req_taken = 1'b0;
  bit bursts_on = 1'b1;
  int send_gap = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  int mismatch_count = 0;
  int result_count = 0;
  int hit_count = 0;
  int fifo_evictions = 0;
  int lru_evictions = 0;
  int flush_count = 0;
  int saturated_count = 0;

  initial begin
    for (int i = 0; i < NUM_FRAMES; i++) begin
      frame_page[i] = '0;
      frame_held[i] = 1'b0;
      frame_rank[i] = '0;
    end
  end

  initial begin
    forever #5 clk = ~clk;
  end

  // Applies one request to the shadow table and returns the result it must produce.
  function automatic lookup_result_t resolve_reference(prf_pkg::opcode_t op,
                                                       logic [15:0] page);
    lookup_result_t r;
    int used;
    int old_rank;
    bit found;
    bit empty_slot;
    r = '0;
    used = 0;
    old_rank = 0;
    found = 1'b0;
    empty_slot = 1'b0;
    if (op == prf_pkg::OP_FLUSH) begin
      for (int i = 0; i < NUM_FRAMES; i++) begin
        frame_held[i] = 1'b0;
        frame_rank[i] = '0;
      end
      oldest_frame = '0;
      fault_tally = '0;
      return r;
    end
    // The lowest matching frame wins.
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (!found && frame_held[i] && frame_page[i] == page) begin
        used = i;
        found = 1'b1;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      old_rank = frame_rank[used];
    end else begin
      for (int i = 0; i < NUM_FRAMES; i++) begin
        if (!empty_slot && !frame_held[i]) begin
          used = i;
          empty_slot = 1'b1;
        end
      end
      if (empty_slot) begin
        // A freshly filled frame is older than every valid one.
        frame_held[used] = 1'b1;
        old_rank = NUM_FRAMES;
      end else begin
        if (policy == prf_pkg::POLICY_LRU) begin
          used = 0;
          for (int i = 1; i < NUM_FRAMES; i++) begin
            if (frame_rank[i] > frame_rank[used]) used = i;
          end
        end else begin
          used = oldest_frame;
          oldest_frame = oldest_frame + 2'd1;
        end
        r.evicted_valid = 1'b1;
        r.evicted_page = frame_page[used];
        old_rank = frame_rank[used];
      end
      frame_page[used] = page;
      if (fault_tally != 16'hFFFF) fault_tally = fault_tally + 16'd1;
    end
    // Age every valid frame that was more recent than the used one.
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (i != used && frame_held[i] && frame_rank[i] < old_rank) begin
        frame_rank[i] = frame_rank[i] + 2'd1;
      end
    end
    frame_rank[used] = '0;
    r.frame_index = 2'(used);
    r.fault_count = fault_tally;
    return r;
  endfunction

  task automatic queue_request(prf_pkg::opcode_t op, logic [15:0] page);
    page_request_t req;
    req.op = op;
    req.page = page;
    page_requests.push_back(req);
  endtask

  // Mostly references to a small hot set, so hits and evictions both occur.
  task automatic queue_random_refs(int count);
    logic [15:0] hot_pages [8];
    int hot_n;
    int roll;
    page_request_t req;
    hot_n = $urandom_range(3, 8);
    for (int k = 0; k < 8; k++) hot_pages[k] = 16'($urandom);
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      req.page = 16'($urandom);
      if (roll < 3) begin
        req.op = prf_pkg::OP_FLUSH;
      end else begin
        req.op = prf_pkg::OP_REFERENCE;
        if (roll < 90) req.page = hot_pages[$urandom_range(0, hot_n - 1)];
      end
      page_requests.push_back(req);
    end
  endtask

  // Holds off until every request is sent and every result has come back.
  task automatic wait_for_drain();
    while (page_requests.size() != 0 || s_tvalid || lookup_results_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (2) @(negedge clk);
  endtask

  task automatic write_policy(prf_pkg::policy_t p);
    @(negedge clk);
    cfg_wen = 1'b1;
    cfg_wdata = p;
    @(negedge clk);
    cfg_wen = 1'b0;
    policy = p;
  endtask

  // Request driver: valid stays up until the beat is taken.
  always @(negedge clk) begin
    if (!rst) begin
      if (s_tvalid && req_taken) page_requests.delete(0);
      if (s_tvalid && !req_taken) begin
        // Hold the current beat.
      end else if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (page_requests.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 11) == 0) begin
        send_gap = $urandom_range(0, 5);
        s_tvalid <= 1'b0;
      end else begin
        s_tvalid <= 1'b1;
        s_tuser <= page_requests[0].op;
        s_tdata <= page_requests[0].page;
      end
    end
  end

  // Result receiver with random stall bursts.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (bursts_on && !rst && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 5);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Monitor: predict on each request beat, then check each result beat.
  always @(posedge clk) begin
    lookup_result_t want;
    lookup_result_t got;
    req_taken = 1'b0;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        req_taken = 1'b1;
        want = resolve_reference(prf_pkg::opcode_t'(s_tuser), s_tdata);
        lookup_results_due.push_back(want);
        if (prf_pkg::opcode_t'(s_tuser) == prf_pkg::OP_FLUSH) flush_count++;
        if (want.hit) hit_count++;
        if (want.evicted_valid && policy == prf_pkg::POLICY_LRU) lru_evictions++;
        if (want.evicted_valid && policy == prf_pkg::POLICY_FIFO) fifo_evictions++;
        if (want.fault_count == 16'hFFFF) saturated_count++;
      end
      if (m_tvalid && m_tready) begin
        got = lookup_result_t'(m_tdata[35:0]);
        if (lookup_results_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result beat %0d arrived with no request pending: %h",
                     result_count, m_tdata);
          end
        end else begin
          want = lookup_results_due.pop_front();
          if (got !== want || m_tdata[39:36] !== 4'd0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display({"result beat %0d mismatch: expected hit=%0b frame=%0d ",
                        "evict=%0b page=%h faults=%0d"},
                       result_count, want.hit, want.frame_index, want.evicted_valid,
                       want.evicted_page, want.fault_count);
              $display("  actual hit=%0b frame=%0d evict=%0b page=%h faults=%0d pad=%h",
                       got.hit, got.frame_index, got.evicted_valid, got.evicted_page,
                       got.fault_count, m_tdata[39:36]);
            end
          end
        end
        result_count++;
      end
    end
  end

  // Watchdog on cycles with no beat on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    logic [15:0] base;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // FIFO: fill in index order, hit, then evict round robin.
    write_policy(prf_pkg::POLICY_FIFO);
    queue_request(prf_pkg::OP_FLUSH, 16'hFFFF);
    queue_request(prf_pkg::OP_REFERENCE, 16'h0000);
    queue_request(prf_pkg::OP_REFERENCE, 16'hFFFF);
    queue_request(prf_pkg::OP_REFERENCE, 16'h5555);
    queue_request(prf_pkg::OP_REFERENCE, 16'hAAAA);
    queue_request(prf_pkg::OP_REFERENCE, 16'hFFFF);
    queue_request(prf_pkg::OP_REFERENCE, 16'h1234);
    queue_request(prf_pkg::OP_REFERENCE, 16'h0000);
    queue_request(prf_pkg::OP_REFERENCE, 16'hAAAA);
    queue_request(prf_pkg::OP_REFERENCE, 16'h0F0F);
    queue_request(prf_pkg::OP_REFERENCE, 16'h1234);
    wait_for_drain();

    // LRU on the same full table, then a flush and a refill from frame 0.
    write_policy(prf_pkg::POLICY_LRU);
    queue_request(prf_pkg::OP_REFERENCE, 16'hAAAA);
    queue_request(prf_pkg::OP_REFERENCE, 16'h1234);
    queue_request(prf_pkg::OP_REFERENCE, 16'h8001);
    queue_request(prf_pkg::OP_REFERENCE, 16'h7FFE);
    queue_request(prf_pkg::OP_REFERENCE, 16'h1234);
    queue_request(prf_pkg::OP_REFERENCE, 16'hC3C3);
    queue_request(prf_pkg::OP_FLUSH, 16'h0000);
    queue_request(prf_pkg::OP_REFERENCE, 16'h00FF);
    queue_request(prf_pkg::OP_REFERENCE, 16'h00FF);
    queue_request(prf_pkg::OP_REFERENCE, 16'hFF00);
    wait_for_drain();

    // Random phases alternating between the two policies.
    for (int ph = 0; ph < 4; ph++) begin
      write_policy(prf_pkg::policy_t'(ph % 2));
      queue_random_refs(100);
      wait_for_drain();
    end

    // A run of distinct pages, so every reference faults and, once the frames are full, evicts.
    write_policy(prf_pkg::POLICY_LRU);
    queue_request(prf_pkg::OP_FLUSH, 16'h0000);
    base = 16'($urandom);
    for (int k = 0; k < MISS_RUN; k++) queue_request(prf_pkg::OP_REFERENCE, base + 16'(k));
    queue_random_refs(40);
    wait_for_drain();

    // Closing phase at full rate on both sides.
    bursts_on = 1'b0;
    write_policy(prf_pkg::policy_t'($urandom_range(0, 1)));
    queue_random_refs(100);
    wait_for_drain();
    repeat (5) @(posedge clk);

    $display("Checked %0d results: %0d hits, %0d FIFO and %0d LRU evictions, %0d flushes,",
             result_count, hit_count, fifo_evictions, lru_evictions, flush_count);
    $display("and %0d results with the fault count saturated; %0d mismatches.",
             saturated_count, mismatch_count);
    if (mismatch_count == 0 && lookup_results_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
